### hw/rtl/tps_pkg.sv
// tps_pkg: shared widths, phase and register codes, and sideband types for the
// trapezoid pulse source. No dependencies.
`default_nettype none

package tps_pkg;

    localparam int TW    = 32;  // tick width
    localparam int LW    = 16;  // level width, Q8.8
    localparam int CW    = 16;  // cycle count width
    localparam int QW    = 16;  // ramp quotient width (|delta| < 2^16)
    localparam int PRODW = 48;  // |delta| * elapsed
    localparam int IDXW  = 3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    localparam logic [IDXW-1:0] REG_LEVEL_LOW  = 3'd0;
    localparam logic [IDXW-1:0] REG_LEVEL_HIGH = 3'd1;
    localparam logic [IDXW-1:0] REG_DELAY      = 3'd2;
    localparam logic [IDXW-1:0] REG_RISE       = 3'd3;
    localparam logic [IDXW-1:0] REG_FALL       = 3'd4;
    localparam logic [IDXW-1:0] REG_ON         = 3'd5;
    localparam logic [IDXW-1:0] REG_PERIOD     = 3'd6;
    localparam logic [IDXW-1:0] REG_CYCLES     = 3'd7;

    typedef struct packed {
        logic win;
    } mod_side_t;

    typedef struct packed {
        logic signed [LW-1:0] base;
        logic                 neg;
        logic [1:0]           phase;
    } div_side_t;

endpackage

`default_nettype wire

### hw/rtl/tps_mod_pipe.sv
// tps_mod_pipe: pipelined restoring remainder, one dividend bit per stage.
// Depends on tps_pkg.
`default_nettype none

module tps_mod_pipe import tps_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [TW-1:0] in_x,
    input  wire mod_side_t     in_side,
    input  wire logic [TW-1:0] period,
    output logic               out_valid,
    output logic [TW-1:0]      out_rem,
    output mod_side_t          out_side
);

    logic            vld_reg  [TW];
    logic [TW-1:0]   rem_reg  [TW];
    logic [TW-1:0]   x_reg    [TW];
    mod_side_t       side_reg [TW];
    logic [TW-1:0]   rem_next [TW];
    logic [TW-1:0]   x_next   [TW];
    logic [TW-1:0]   src_rem  [TW];
    logic [TW-1:0]   src_x    [TW];
    logic [TW:0]     trial    [TW];

    always_comb
    begin
        src_rem[0] = '0;
        src_x[0]   = in_x;
        for (int k = 1; k < TW; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_x[k]   = x_reg[k-1];
        end
        for (int k = 0; k < TW; k++)
        begin
            trial[k] = {src_rem[k], src_x[k][TW-1]};
            if (trial[k] >= {1'b0, period})
                rem_next[k] = TW'(trial[k] - {1'b0, period});
            else
                rem_next[k] = trial[k][TW-1:0];
            x_next[k] = {src_x[k][TW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TW; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < TW; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < TW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                x_reg[k]   <= x_next[k];
            end
            for (int k = 1; k < TW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = vld_reg[TW-1];
    assign out_rem   = rem_reg[TW-1];
    assign out_side  = side_reg[TW-1];

endmodule

`default_nettype wire

### hw/rtl/tps_div_pipe.sv
// tps_div_pipe: pipelined restoring divider, one quotient bit per stage;
// quotient is known to fit QW bits. Depends on tps_pkg.
`default_nettype none

module tps_div_pipe import tps_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [PRODW-1:0] in_prod,
    input  wire logic [TW-1:0]    in_den,
    input  wire div_side_t        in_side,
    output logic                  out_valid,
    output logic [QW-1:0]         out_quo,
    output div_side_t             out_side
);

    logic             vld_reg  [QW];
    logic [PRODW-1:0] rem_reg  [QW];
    logic [TW-1:0]    den_reg  [QW];
    logic [QW-1:0]    q_reg    [QW];
    div_side_t        side_reg [QW];
    logic [PRODW-1:0] rem_next [QW];
    logic [QW-1:0]    q_next   [QW];
    logic [PRODW-1:0] src_rem  [QW];
    logic [TW-1:0]    src_den  [QW];
    logic [QW-1:0]    src_q    [QW];
    logic [PRODW-1:0] shifted  [QW];

    always_comb
    begin
        src_rem[0] = in_prod;
        src_den[0] = in_den;
        src_q[0]   = '0;
        for (int k = 1; k < QW; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_den[k] = den_reg[k-1];
            src_q[k]   = q_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            shifted[k] = PRODW'(src_den[k]) << (QW - 1 - k);
            if (src_rem[k] >= shifted[k])
            begin
                rem_next[k] = src_rem[k] - shifted[k];
                q_next[k]   = {src_q[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = src_rem[k];
                q_next[k]   = {src_q[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < QW; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < QW; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= src_den[k];
                q_reg[k]   <= q_next[k];
            end
            for (int k = 1; k < QW; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

### hw/rtl/trapezoid_pulse_source.sv
// trapezoid_pulse_source: top level; config registers, window check, phase
// classification, ramp multiply and output register. Uses tps_pkg, tps_mod_pipe, tps_div_pipe.
`default_nettype none

// Evaluates a trapezoidal pulse (delay, rise, on, fall, period, cycle count)
// at one tick time per word and returns the Q8.8 level and the phase code.
// One word is accepted every cycle while in_ready is high; on its way to the result
// word it passes one window stage, 32 remainder stages (one bit each of
// the 32-bit time offset modulo the period), a classify stage, a multiply
// stage, 16 ramp-divide stages (one quotient bit each) and the output
// register. The whole pipeline advances together and holds while a result
// word waits at the output; in_ready is high whenever the output register is
// empty or being taken. Configuration writes take effect on the next cycle
// and are to be made with no words in flight. Ramps truncate toward zero; a
// zero rise or fall length uses MIN_RAMP_TICKS.

module trapezoid_pulse_source import tps_pkg::*; #(
    parameter int MIN_RAMP_TICKS = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [TW-1:0]        time_ticks,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [LW-1:0]      level,
    output logic [1:0]                phase,
    input  wire logic                 cfg_we,
    input  wire logic [IDXW-1:0]      cfg_index,
    input  wire logic [TW-1:0]        cfg_data
);

    localparam logic [TW-1:0] MinRamp = TW'(MIN_RAMP_TICKS);

    // configuration
    logic signed [LW-1:0] level_low_reg;
    logic signed [LW-1:0] level_high_reg;
    logic [TW-1:0]        delay_reg;
    logic [TW-1:0]        rise_reg;
    logic [TW-1:0]        fall_reg;
    logic [TW-1:0]        on_reg;
    logic [TW-1:0]        period_reg;
    logic [CW-1:0]        cycles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_low_reg  <= '0;
            level_high_reg <= '0;
            delay_reg      <= '0;
            rise_reg       <= '0;
            fall_reg       <= '0;
            on_reg         <= '0;
            period_reg     <= TW'(1);
            cycles_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEVEL_LOW:  level_low_reg  <= cfg_data[LW-1:0];
                REG_LEVEL_HIGH: level_high_reg <= cfg_data[LW-1:0];
                REG_DELAY:      delay_reg      <= cfg_data;
                REG_RISE:       rise_reg       <= cfg_data;
                REG_FALL:       fall_reg       <= cfg_data;
                REG_ON:         on_reg         <= cfg_data;
                REG_PERIOD:     period_reg     <= cfg_data;
                REG_CYCLES:     cycles_reg     <= cfg_data[CW-1:0];
                default:        ;
            endcase
        end
    end

    // global advance: everything moves unless a result word is stuck
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: offset from delay, window length
    logic                 s1_vld_reg;
    logic [TW-1:0]        s1_x_reg;
    logic                 s1_gt_reg;
    logic [TW+CW-1:0]     s1_pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg  <= time_ticks - delay_reg;
            s1_gt_reg <= time_ticks > delay_reg;
            s1_pc_reg <= period_reg * cycles_reg;
        end
    end

    // inside the pulse train: delay < t <= delay + period * cycles
    mod_side_t mod_in_side;
    assign mod_in_side.win = s1_gt_reg && ((TW+CW)'(s1_x_reg) <= s1_pc_reg)
                             && (period_reg != '0);

    logic          mod_vld;
    logic [TW-1:0] mod_rem;
    mod_side_t     mod_side;

    tps_mod_pipe u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_vld_reg),
        .in_x      (s1_x_reg),
        .in_side   (mod_in_side),
        .period    (period_reg),
        .out_valid (mod_vld),
        .out_rem   (mod_rem),
        .out_side  (mod_side)
    );

    // classify: pick ramp endpoints, elapsed ticks and ramp length.
    // Flat phases use delta 0 so the divider returns 0.
    logic [TW-1:0]        rise_eff;
    logic [TW-1:0]        fall_eff;
    logic [TW:0]          top;
    logic [TW+1:0]        top_fall;
    logic [1:0]           cls_phase;
    logic signed [LW-1:0] cls_a;
    logic signed [LW-1:0] cls_b;
    logic [TW-1:0]        cls_num;
    logic [TW-1:0]        cls_den;
    logic signed [LW:0]   cls_delta;
    logic [LW:0]          cls_mag;

    always_comb
    begin
        rise_eff  = (rise_reg == '0) ? MinRamp : rise_reg;
        fall_eff  = (fall_reg == '0) ? MinRamp : fall_reg;
        top       = {1'b0, rise_eff} + {1'b0, on_reg};
        top_fall  = {1'b0, top} + {2'b0, fall_eff};
        cls_phase = PH_IDLE;
        cls_a     = level_low_reg;
        cls_b     = level_low_reg;
        cls_num   = '0;
        cls_den   = TW'(1);
        if (mod_side.win)
        begin
            if (mod_rem < rise_eff)
            begin
                cls_phase = PH_RISE;
                cls_b     = level_high_reg;
                cls_num   = mod_rem;
                cls_den   = rise_eff;
            end
            else if ({1'b0, mod_rem} <= top)
            begin
                cls_phase = PH_HIGH;
                cls_a     = level_high_reg;
                cls_b     = level_high_reg;
            end
            else if ({2'b0, mod_rem} < top_fall)
            begin
                cls_phase = PH_FALL;
                cls_a     = level_high_reg;
                cls_num   = TW'({1'b0, mod_rem} - top);
                cls_den   = fall_eff;
            end
        end
        cls_delta = {cls_b[LW-1], cls_b} - {cls_a[LW-1], cls_a};
        cls_mag   = cls_delta[LW] ? -cls_delta : cls_delta;
    end

    logic             c_vld_reg;
    div_side_t        c_side_reg;
    logic [LW-1:0]    c_mag_reg;
    logic [TW-1:0]    c_num_reg;
    logic [TW-1:0]    c_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= mod_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg.base  <= cls_a;
            c_side_reg.neg   <= cls_delta[LW];
            c_side_reg.phase <= cls_phase;
            c_mag_reg        <= cls_mag[LW-1:0];
            c_num_reg        <= cls_num;
            c_den_reg        <= cls_den;
        end
    end

    // multiply: |delta| * elapsed
    logic             m_vld_reg;
    div_side_t        m_side_reg;
    logic [PRODW-1:0] m_prod_reg;
    logic [TW-1:0]    m_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (en)
            m_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= c_side_reg;
            m_prod_reg <= c_mag_reg * c_num_reg;
            m_den_reg  <= c_den_reg;
        end
    end

    logic          d_vld;
    logic [QW-1:0] d_quo;
    div_side_t     d_side;

    tps_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_vld_reg),
        .in_prod   (m_prod_reg),
        .in_den    (m_den_reg),
        .in_side   (m_side_reg),
        .out_valid (d_vld),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    // final: base +/- quotient, wrapped to 16 bits
    logic [LW:0] step;
    logic [LW:0] sum;
    assign step = d_side.neg ? -{1'b0, d_quo} : {1'b0, d_quo};
    assign sum  = {d_side.base[LW-1], d_side.base} + step;

    logic signed [LW-1:0] level_reg;
    logic [1:0]           phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg <= sum[LW-1:0];
            phase_reg <= d_side.phase;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign phase     = phase_reg;

    // checks
    a_high_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == PH_HIGH) |-> level == level_high_reg)
        else $error("high phase level mismatch");

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == PH_IDLE) |-> level == level_low_reg)
        else $error("idle phase level mismatch");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for trapezoid_pulse_source; predicts level and phase per
// time word and checks each result word in order. Depends on tps_pkg and the block RTL.
`default_nettype none

module tb_top;
    import tps_pkg::*;

    localparam int MIN_RAMP = 1;
    localparam int LATENCY  = 52;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [TW-1:0]          time_ticks;
    logic                   out_valid;
    logic                   out_ready;
    logic signed [LW-1:0]   level;
    logic [1:0]             phase;
    logic                   cfg_we;
    logic [IDXW-1:0]        cfg_index;
    logic [TW-1:0]          cfg_data;

    trapezoid_pulse_source #(.MIN_RAMP_TICKS(MIN_RAMP)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .time_ticks(time_ticks),
        .out_valid(out_valid), .out_ready(out_ready), .level(level), .phase(phase),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor's private copy of the registers
    logic signed [LW-1:0]   m_low, m_high;
    logic [TW-1:0]          m_delay, m_rise, m_fall, m_on, m_period;
    logic [CW-1:0]          m_cycles;

    typedef struct packed {
        logic signed [LW-1:0] lvl;
        logic [1:0]           ph;
    } sample_t;

    sample_t pending_samples[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // a + (b - a) * num / den, truncated toward zero
    function automatic logic signed [LW-1:0] lerp(input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b,
                                                  input longint num, input longint den);
        longint delta;
        longint q;
        delta = longint'(b) - longint'(a);
        q = (delta * num) / den;
        return LW'(longint'(a) + q);
    endfunction

    function automatic sample_t pulse_at(input logic [TW-1:0] t);
        sample_t s;
        longint rise, fall, top, stop, p, tl;
        rise = (m_rise == 0) ? MIN_RAMP : longint'(m_rise);
        fall = (m_fall == 0) ? MIN_RAMP : longint'(m_fall);
        stop = longint'(m_delay) + longint'(m_period) * longint'(m_cycles);
        tl = longint'(t);
        s.lvl = m_low;
        s.ph  = PH_IDLE;
        if (tl > longint'(m_delay) && tl <= stop && m_period != 0)
        begin
            p = (tl - longint'(m_delay)) % longint'(m_period);
            top = rise + longint'(m_on);
            if (p < rise)
            begin
                s.lvl = lerp(m_low, m_high, p, rise);
                s.ph  = PH_RISE;
            end
            else if (p <= top)
            begin
                s.lvl = m_high;
                s.ph  = PH_HIGH;
            end
            else if (p < top + fall)
            begin
                s.lvl = lerp(m_high, m_low, p - top, fall);
                s.ph  = PH_FALL;
            end
        end
        return s;
    endfunction

    // register write; only called with the pipe drained; caller drops cfg_we
    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [TW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_LEVEL_LOW:  m_low    = val[LW-1:0];
            REG_LEVEL_HIGH: m_high   = val[LW-1:0];
            REG_DELAY:      m_delay  = val;
            REG_RISE:       m_rise   = val;
            REG_FALL:       m_fall   = val;
            REG_ON:         m_on     = val;
            REG_PERIOD:     m_period = val;
            REG_CYCLES:     m_cycles = val[CW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_pulse(input int lo, input int hi, input logic [TW-1:0] dly,
                             input logic [TW-1:0] rs, input logic [TW-1:0] fl,
                             input logic [TW-1:0] on, input logic [TW-1:0] per,
                             input int cyc);
        write_reg(REG_LEVEL_LOW, TW'(lo));
        write_reg(REG_LEVEL_HIGH, TW'(hi));
        write_reg(REG_DELAY, dly);
        write_reg(REG_RISE, rs);
        write_reg(REG_FALL, fl);
        write_reg(REG_ON, on);
        write_reg(REG_PERIOD, per);
        write_reg(REG_CYCLES, TW'(cyc));
        cfg_we <= 1'b0;
    endtask

    // sends one time word, idling first at the current rate; valid stays
    // high afterwards until the next idle cycle or stop_sending
    task automatic send_time(input logic [TW-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        time_ticks <= t;
        pending_samples.push_back(pulse_at(t));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_sending;
        in_valid <= 1'b0;
    endtask

    task automatic drain;
        stop_sending();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // time mostly from the delay up to one period past the pulse train, else any time
    function automatic logic [TW-1:0] pick_time;
        longint base, span, off;
        if ($urandom_range(9) == 0)
            return $urandom;
        span = longint'(m_period) * (longint'(m_cycles) + 1);
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        off = (span == 0) ? 0 : longint'({$urandom, $urandom}) % (span + 2);
        if (off < 0) off = -off;
        base = longint'(m_delay) + off;
        return TW'(base);
    endfunction

    task automatic test_reset_values;
        // registers at reset: everything sits at zero but a period of one, idle
        send_time('0);
        send_time(32'd1);
        send_time('1);
        drain();
    endtask

    task automatic test_directed;
        set_pulse(-32768, 32767, 10, 4, 3, 2, 12, 2);
        for (int t = 8; t <= 36; t++)
            send_time(TW'(t));
        send_time('1);
        drain();
        // zero ramps use the minimum ramp, high below low
        set_pulse(32767, -32768, 0, 0, 0, 0, 5, 65535);
        send_time(32'd1); send_time(32'd2); send_time(32'd3);
        send_time(32'd5); send_time(32'd327675); send_time(32'd327676);
        drain();
        // zero period: always idle
        set_pulse(256, -256, 3, 2, 2, 1, 0, 5);
        send_time(32'd4); send_time(32'd7);
        drain();
        // near-widest delay, widest period, huge window
        set_pulse(-1, 1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 65535);
        send_time(32'hFFFF_FFF0); send_time(32'hFFFF_FFF1); send_time('1);
        drain();
        // ramp that spans most of a period
        set_pulse(-20000, 30000, 1, 32'h8000_0000, 32'h7000_0000, 5, 32'hF000_0010, 1);
        send_time(32'h4000_0000); send_time(32'h8000_0004); send_time(32'hC000_0000);
        drain();
    endtask

    task automatic random_config;
        logic [TW-1:0] per;
        per = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
        set_pulse($urandom_range(65535), $urandom_range(65535),
                  ($urandom_range(7) == 0) ? $urandom : $urandom_range(40),
                  $urandom_range(20), $urandom_range(20), $urandom_range(20), per,
                  ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(6));
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int words);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 4; k++)
        begin
            random_config();
            for (int n = 0; n < words / 4; n++)
                send_time(pick_time());
            drain();
        end
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        hold_off_cycles = 120;
        // the output stalls while the sender keeps offering words
        for (int n = 0; n < 80; n++)
            send_time(pick_time());
        // sender waits for every result before going on
        stop_sending();
        while (pending_samples.size() != 0)
            @(posedge clk);
        for (int n = 0; n < 20; n++)
            send_time(pick_time());
        drain();
    endtask

    // receiver: random idling plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("result word with nothing pending: level %0d phase %0d",
                       level, phase);
                fail_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (level !== want.lvl)
                begin
                    $error("level: expected %0d, got %0d", want.lvl, level);
                    fail_count++;
                end
                if (phase !== want.ph)
                begin
                    $error("phase: expected %0d, got %0d", want.ph, phase);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #6000000;
        $display("** trapezoid_pulse_source: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        time_ticks = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        m_low = 0; m_high = 0; m_delay = 0; m_rise = 0; m_fall = 0; m_on = 0;
        m_period = 1; m_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_random(17, 72, 136);
        test_random(72, 17, 136);
        test_random(0, 0, 136);
        test_backpressure();

        if (fail_count == 0)
            $display("** trapezoid_pulse_source: PASSED **");
        else
            $display("** trapezoid_pulse_source: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
hw/rtl/tps_pkg.sv
hw/rtl/tps_mod_pipe.sv
hw/rtl/tps_div_pipe.sv
hw/rtl/trapezoid_pulse_source.sv
bench/tb_top.sv
